// ===== rtl/atfb_pkg.sv =====
// ----------------------------------------------------------------------------
// atfb_pkg
// types and constants shared by the transmit frame builder
// ----------------------------------------------------------------------------
`default_nettype none

package atfb_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned IdxW  = 3;

  localparam logic [7:0] FRAME_SOF   = 8'h7E;
  localparam logic [7:0] LEN_MSB     = 8'h00;
  localparam logic [7:0] LEN_BASE    = 8'h05;
  localparam logic [7:0] API_TX16    = 8'h01;
  localparam logic [7:0] CSUM_BASE   = 8'hFF;
  localparam logic [7:0] SUM_INIT    = 8'h00;

  // header byte positions
  localparam logic [IdxW-1:0] HDR_SOF    = 3'd0;
  localparam logic [IdxW-1:0] HDR_LEN_HI = 3'd1;
  localparam logic [IdxW-1:0] HDR_LEN_LO = 3'd2;
  localparam logic [IdxW-1:0] HDR_API    = 3'd3;
  localparam logic [IdxW-1:0] HDR_IDENT  = 3'd4;
  localparam logic [IdxW-1:0] HDR_DST_HI = 3'd5;
  localparam logic [IdxW-1:0] HDR_DST_LO = 3'd6;
  localparam logic [IdxW-1:0] HDR_OPTS   = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_DEST  = 2'd0;
  localparam logic [1:0] CFG_IDENT = 2'd1;
  localparam logic [1:0] CFG_OPTS  = 2'd2;

  localparam logic [15:0] DEST_RST  = 16'hFFFF;
  localparam logic [7:0]  IDENT_RST = 8'h00;
  localparam logic [7:0]  OPTS_RST  = 8'h01;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             first;
    logic             last;
    logic [LenW-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic [15:0] dest;
    logic [7:0]  ident;
    logic [7:0]  opts;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_START,
    ST_HDR,
    ST_DATA,
    ST_CSUM
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/atfb_front.sv =====
// ----------------------------------------------------------------------------
// atfb_front
// accepts payload bytes, tracks the open frame and marks first and last bytes
// ----------------------------------------------------------------------------
`default_nettype none

module atfb_front import atfb_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 100
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic [LenW-1:0]  payload_length_i,
  output entry_t                entry_o
);

  localparam logic [LenW:0] MaxLen = (LenW + 1)'(MAX_PAYLOAD);

  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic [LenW:0]   len_raw;
  logic [LenW:0]   len_sat;
  logic [LenW-1:0] len;

  always_comb begin
    len_raw = {1'b0, payload_length_i};
    len_sat = len_raw;
    if (len_raw == '0) begin
      len_sat = (LenW + 1)'(1);
    end
    if (len_sat > MaxLen) begin
      len_sat = MaxLen;
    end
    len = len_sat[LenW-1:0];
  end

  always_comb begin
    entry_o.data = data_byte_i;
    entry_o.len  = len;
    if (bytes_left_q == '0) begin
      entry_o.first = 1'b1;
      entry_o.last  = (len == LenW'(1));
      bytes_left_d  = len - LenW'(1);
    end else begin
      entry_o.first = 1'b0;
      entry_o.last  = (bytes_left_q == LenW'(1));
      bytes_left_d  = bytes_left_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
    end else if (accept_i) begin
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atfb_queue.sv =====
// ----------------------------------------------------------------------------
// atfb_queue
// two-entry queue between the byte classifier and the frame sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module atfb_queue import atfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    push_entry_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output entry_t    head_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atfb_back.sv =====
// ----------------------------------------------------------------------------
// atfb_back
// frame sequencer: header, payload and checksum bytes into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module atfb_back import atfb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  entry_t                head_i,
  output logic                  pop_o,
  input  cfg_t                  cfg_i,
  output logic                  out_valid_o,
  output logic [DataW-1:0]      out_byte_o,
  output logic                  out_end_o,
  input  wire logic             out_ready_i
);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_end_q;

  logic            adv;
  logic            emit;
  logic [7:0]      byte_c;
  logic            end_c;
  logic [7:0]      hdr_byte;

  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    case (idx_q)
      HDR_SOF:    hdr_byte = FRAME_SOF;
      HDR_LEN_HI: hdr_byte = LEN_MSB;
      HDR_LEN_LO: hdr_byte = LEN_BASE + {1'b0, head_i.len};
      HDR_API:    hdr_byte = API_TX16;
      HDR_IDENT:  hdr_byte = cfg_i.ident;
      HDR_DST_HI: hdr_byte = cfg_i.dest[15:8];
      HDR_DST_LO: hdr_byte = cfg_i.dest[7:0];
      HDR_OPTS:   hdr_byte = cfg_i.opts;
      default:    hdr_byte = FRAME_SOF;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (adv) begin
      case (state_q)
        ST_START: begin
          if (head_valid_i) begin
            if (head_i.first) begin
              state_d = ST_HDR;
            end else if (head_i.last) begin
              state_d = ST_CSUM;
            end
          end
        end
        ST_HDR: begin
          if (idx_q == HDR_OPTS) begin
            state_d = ST_DATA;
          end
        end
        ST_DATA: begin
          state_d = head_i.last ? ST_CSUM : ST_START;
        end
        ST_CSUM: begin
          state_d = ST_START;
        end
        default: state_d = ST_START;
      endcase
    end
  end

  // outputs
  always_comb begin
    emit   = 1'b0;
    byte_c = head_i.data;
    end_c  = 1'b0;
    pop_o  = 1'b0;
    sum_d  = sum_q;
    idx_d  = idx_q;
    if (adv) begin
      case (state_q)
        ST_START: begin
          if (head_valid_i) begin
            emit = 1'b1;
            if (head_i.first) begin
              byte_c = FRAME_SOF;
              idx_d  = HDR_LEN_HI;
            end else begin
              byte_c = head_i.data;
              sum_d  = sum_q + head_i.data;
              pop_o  = !head_i.last;
            end
          end
        end
        ST_HDR: begin
          emit   = 1'b1;
          byte_c = hdr_byte;
          idx_d  = idx_q + IdxW'(1);
          if (idx_q >= HDR_API) begin
            sum_d = sum_q + hdr_byte;
          end
        end
        ST_DATA: begin
          emit   = 1'b1;
          byte_c = head_i.data;
          sum_d  = sum_q + head_i.data;
          pop_o  = !head_i.last;
        end
        ST_CSUM: begin
          emit   = 1'b1;
          byte_c = CSUM_BASE - sum_q;
          end_c  = 1'b1;
          sum_d  = SUM_INIT;
          pop_o  = 1'b1;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      idx_q       <= HDR_SOF;
      sum_q       <= SUM_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_byte_q <= byte_c;
      out_end_q  <= end_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;

endmodule

`default_nettype wire

// ===== rtl/api_tx16_frame_builder.sv =====
// ----------------------------------------------------------------------------
// api_tx16_frame_builder
// wraps a payload byte stream in a 16-bit address api transmit frame
//
// the slave stream takes one payload byte per beat, with the payload length
// beside it; the length is sampled on the first byte of a frame. the master
// stream gives the framed bytes one per beat: start byte, length, frame type,
// frame id, destination, options, payload, then the checksum with tlast set.
// the config channel writes destination, frame id and options by index; it
// is always ready and is meant to be written while no frame is in flight.
// an accepted byte passes through the queue, then the single output register.
// throughput is one output byte per cycle while the queue holds bytes and the
// receiver is ready; a first byte holds the sequencer also for the start byte
// and header, a last byte also for the checksum, any other byte for itself. the
// two-entry queue takes new bytes meanwhile, so input stalls only when it is full.
// a stalled receiver holds the output register and, through it, the queue.
// reset closes any open frame, empties the queue and restores the default
// registers: broadcast destination, frame id zero, options one.
// ----------------------------------------------------------------------------
`default_nettype none

module api_tx16_frame_builder import atfb_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 100
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // data_byte[7:0], payload_length[14:8], zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // frame_byte[7:0]
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic   in_accept;
  entry_t push_entry;
  entry_t head;
  logic   q_full, q_valid, q_pop;
  cfg_t   cfg_q;

  assign s_axis_tready_o = !q_full;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest  <= DEST_RST;
      cfg_q.ident <= IDENT_RST;
      cfg_q.opts  <= OPTS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEST:  cfg_q.dest  <= cfg_data_i;
        CFG_IDENT: cfg_q.ident <= cfg_data_i[7:0];
        CFG_OPTS:  cfg_q.opts  <= cfg_data_i[7:0];
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  atfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .data_byte_i     (s_axis_tdata_i[7:0]),
    .payload_length_i(s_axis_tdata_i[14:8]),
    .entry_o         (push_entry)
  );

  atfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  atfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head),
    .pop_o       (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_end_o   (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("sequencer released an entry from an empty queue");

  a_pop_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid_o)
    else $error("queue entry released without an output byte");

  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !q_pop) |=> q_full)
    else $error("queue left full state without a release");

endmodule

`default_nettype wire
